// ----- sv/gniu_pkg.sv -----
// Package with shared types, constants and helpers for the neighbourhood update block.
package gniu_pkg;

    localparam int PLAYER_SLOTS    = 256;
    localparam int NEIGHBOUR_SLOTS = 9;
    localparam int PID_W           = $clog2(PLAYER_SLOTS);
    localparam int MEM_DEPTH       = PLAYER_SLOTS * NEIGHBOUR_SLOTS;
    localparam int MEM_AW          = $clog2(MEM_DEPTH);
    localparam logic [7:0] NO_AREA = 8'hFF;

    localparam logic [1:0] REG_COLS  = 2'd0;
    localparam logic [1:0] REG_CELL  = 2'd1;
    localparam logic [1:0] REG_APR   = 2'd2;
    localparam logic [1:0] REG_COUNT = 2'd3;

    typedef struct packed {
        logic [7:0]  player_id;
        logic [31:0] position;
    } in_beat_t;

    typedef struct packed {
        logic [3:0] slot;
        logic [7:0] active_area;
        logic [7:0] inactive_area;
        logic       position_bad;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic [15:0] position_columns;
        logic [7:0]  cell_size;
        logic [7:0]  areas_per_row;
        logic [7:0]  area_count;
    } cfg_t;

    // Classified job handed from the front part to the back part.
    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic             bad;
        logic [7:0]       area;
    } job_t;

    typedef enum logic [2:0] {
        FR_IDLE, FR_DIV1, FR_DIV2, FR_DIV3, FR_DIV4, FR_DIV5, FR_MUL, FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_CLEAR, BK_IDLE, BK_READ, BK_CMP, BK_EMIT
    } back_state_t;

endpackage

// ----- sv/gniu_div.sv -----
// Restoring bit-serial divider, one quotient bit per cycle.
module gniu_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [15:0] remainder
);
    logic [31:0] q_reg;
    logic [16:0] r_reg;
    logic [15:0] d_reg;
    logic [5:0]  cnt_reg;
    logic [16:0] shifted;
    logic [17:0] diff;

    assign shifted = {r_reg[15:0], q_reg[31]};
    assign diff    = {1'b0, shifted} - {2'b00, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= 17'd0;
            d_reg <= (divisor == 16'd0) ? 16'd1 : divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            if (!diff[17])
            begin
                r_reg <= diff[16:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign done      = (cnt_reg == 6'd1);
    assign quotient  = (!diff[17]) ? {q_reg[30:0], 1'b1} : {q_reg[30:0], 1'b0};
    assign remainder = (!diff[17]) ? diff[15:0] : shifted[15:0];
endmodule

// ----- sv/gniu_front.sv -----
// Front part: splits the position, computes the area index and classifies it.
module gniu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  gniu_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_stall,
    input  gniu_pkg::in_beat_t in_data,
    output logic            job_valid,
    input  logic            job_stall,
    output gniu_pkg::job_t  job
);
    gniu_pkg::front_state_t state_reg, state_next;
    logic [gniu_pkg::PID_W-1:0] pid_reg;
    logic [31:0] y_reg, row_reg;
    logic [15:0] x_reg;
    logic [15:0] col_reg;
    logic [39:0] area_reg;
    logic [7:0]  cell_div;

    logic        div_start;
    logic [31:0] div_a;
    logic [15:0] div_b;
    logic        div_done;
    logic [31:0] div_q;
    logic [15:0] div_r;

    assign cell_div = (cfg.cell_size == 8'd0) ? 8'd1 : cfg.cell_size;

    gniu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gniu_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        div_start  = 1'b0;
        div_a      = in_data.position;
        div_b      = cfg.position_columns;
        unique case (state_reg)
            gniu_pkg::FR_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    div_start  = 1'b1;
                    state_next = gniu_pkg::FR_DIV1;
                end
            end
            gniu_pkg::FR_DIV1:
            begin
                if (div_done)
                begin
                    state_next = gniu_pkg::FR_DIV2;
                end
            end
            gniu_pkg::FR_DIV2:
            begin
                div_start  = 1'b1;
                div_a      = y_reg;
                div_b      = {8'd0, cell_div};
                state_next = gniu_pkg::FR_DIV3;
            end
            gniu_pkg::FR_DIV3:
            begin
                if (div_done)
                begin
                    state_next = gniu_pkg::FR_DIV4;
                end
            end
            gniu_pkg::FR_DIV4:
            begin
                div_start  = 1'b1;
                div_a      = {16'd0, x_reg};
                div_b      = {8'd0, cell_div};
                state_next = gniu_pkg::FR_DIV5;
            end
            gniu_pkg::FR_DIV5:
            begin
                if (div_done)
                begin
                    state_next = gniu_pkg::FR_MUL;
                end
            end
            gniu_pkg::FR_MUL:
            begin
                state_next = gniu_pkg::FR_PUSH;
            end
            gniu_pkg::FR_PUSH:
            begin
                if (!job_stall)
                begin
                    state_next = gniu_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = gniu_pkg::FR_IDLE;
            end
        endcase
    end

    // The shared divider runs three times: position by columns, then row and
    // column each by the cell size.
    always_ff @(posedge clk)
    begin
        if (state_reg == gniu_pkg::FR_IDLE && in_valid)
        begin
            pid_reg <= in_data.player_id[gniu_pkg::PID_W-1:0];
        end
        if (state_reg == gniu_pkg::FR_DIV1 && div_done)
        begin
            y_reg <= div_q;
            x_reg <= div_r;
        end
        if (state_reg == gniu_pkg::FR_DIV3 && div_done)
        begin
            row_reg <= div_q;
        end
        if (state_reg == gniu_pkg::FR_DIV5 && div_done)
        begin
            col_reg <= div_q[15:0];
        end
        if (state_reg == gniu_pkg::FR_MUL)
        begin
            area_reg <= {8'd0, row_reg} * {32'd0, cfg.areas_per_row} + {24'd0, col_reg};
        end
    end

    assign job_valid = (state_reg == gniu_pkg::FR_PUSH);
    assign job.pid   = pid_reg;
    assign job.bad   = (area_reg >= {32'd0, cfg.area_count});
    assign job.area  = area_reg[7:0];
endmodule

// ----- sv/gniu_queue.sv -----
// Two-entry queue that decouples the front part from the back part.
module gniu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_stall,
    input  gniu_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_stall,
    output gniu_pkg::job_t rd_data
);
    gniu_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end
endmodule

// ----- sv/gniu_back.sv -----
// Back part: builds the neighbourhood, diffs it against the stored set, emits beats.
module gniu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  gniu_pkg::cfg_t  cfg,
    input  logic            job_valid,
    output logic            job_stall,
    input  gniu_pkg::job_t  job,
    output logic            out_valid,
    input  logic            out_stall,
    output gniu_pkg::out_beat_t out_data
);
    gniu_pkg::back_state_t state_reg, state_next;
    logic [7:0] mem [gniu_pkg::MEM_DEPTH];
    logic [7:0] rdata_reg;
    logic [gniu_pkg::MEM_AW-1:0] clr_reg;

    logic [gniu_pkg::PID_W-1:0] pid_reg;
    logic [7:0] fresh_reg [gniu_pkg::NEIGHBOUR_SLOTS];
    logic [7:0] drop_reg  [gniu_pkg::NEIGHBOUR_SLOTS];
    logic [3:0] rd_idx_reg, cmp_idx_reg, drop_cnt_reg, emit_reg;
    logic       bad_reg;
    logic [gniu_pkg::MEM_AW-1:0] base;
    logic [gniu_pkg::MEM_AW-1:0] rd_addr, wr_addr;
    logic       mem_we;
    logic [gniu_pkg::MEM_AW-1:0] mem_waddr;
    logic [7:0] mem_wdata;
    logic [7:0] stored_val;
    logic       found;
    logic [9:0] cand [gniu_pkg::NEIGHBOUR_SLOTS];
    logic       emit_go;

    assign base     = gniu_pkg::MEM_AW'(pid_reg * gniu_pkg::NEIGHBOUR_SLOTS);
    assign rd_addr  = base + gniu_pkg::MEM_AW'(rd_idx_reg);
    assign wr_addr  = base + gniu_pkg::MEM_AW'(emit_reg);

    assign stored_val = rdata_reg;

    always_comb
    begin
        found = 1'b0;
        for (int j = 0; j < gniu_pkg::NEIGHBOUR_SLOTS; j++)
        begin
            if (stored_val == fresh_reg[j])
            begin
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [9:0] a, w;
        a = {2'b00, job.area};
        w = {2'b00, cfg.areas_per_row};
        cand[0] = a - w - 10'd1;
        cand[1] = a - w;
        cand[2] = a - w + 10'd1;
        cand[3] = a - 10'd1;
        cand[4] = a;
        cand[5] = a + 10'd1;
        cand[6] = a + w - 10'd1;
        cand[7] = a + w;
        cand[8] = a + w + 10'd1;
    end

    assign emit_go = (state_reg == gniu_pkg::BK_EMIT) && !out_stall;

    // After reset the clearing pass fills the whole store with no area.
    assign mem_we    = (state_reg == gniu_pkg::BK_CLEAR) || (emit_go && !bad_reg);
    assign mem_waddr = (state_reg == gniu_pkg::BK_CLEAR) ? clr_reg : wr_addr;
    assign mem_wdata = (state_reg == gniu_pkg::BK_CLEAR) ? gniu_pkg::NO_AREA
                                                         : fresh_reg[emit_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gniu_pkg::BK_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gniu_pkg::BK_CLEAR)
            begin
                clr_reg <= clr_reg + gniu_pkg::MEM_AW'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_stall  = 1'b1;
        unique case (state_reg)
            gniu_pkg::BK_CLEAR:
            begin
                if (clr_reg == gniu_pkg::MEM_AW'(gniu_pkg::MEM_DEPTH - 1))
                begin
                    state_next = gniu_pkg::BK_IDLE;
                end
            end
            gniu_pkg::BK_IDLE:
            begin
                job_stall = 1'b0;
                if (job_valid)
                begin
                    state_next = job.bad ? gniu_pkg::BK_EMIT : gniu_pkg::BK_READ;
                end
            end
            gniu_pkg::BK_READ:
            begin
                state_next = gniu_pkg::BK_CMP;
            end
            gniu_pkg::BK_CMP:
            begin
                if (cmp_idx_reg == 4'(gniu_pkg::NEIGHBOUR_SLOTS - 1))
                begin
                    state_next = gniu_pkg::BK_EMIT;
                end
            end
            gniu_pkg::BK_EMIT:
            begin
                if (!out_stall && (bad_reg ||
                    emit_reg == 4'(gniu_pkg::NEIGHBOUR_SLOTS - 1)))
                begin
                    state_next = gniu_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = gniu_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == gniu_pkg::BK_IDLE && job_valid)
        begin
            pid_reg      <= job.pid;
            bad_reg      <= job.bad;
            rd_idx_reg   <= 4'd0;
            cmp_idx_reg  <= 4'd0;
            drop_cnt_reg <= 4'd0;
            emit_reg     <= 4'd0;
            for (int i = 0; i < gniu_pkg::NEIGHBOUR_SLOTS; i++)
            begin
                fresh_reg[i] <= (!cand[i][9] && cand[i][8:0] < {1'b0, cfg.area_count})
                                ? cand[i][7:0] : gniu_pkg::NO_AREA;
                drop_reg[i]  <= gniu_pkg::NO_AREA;
            end
        end
        if (state_reg == gniu_pkg::BK_READ)
        begin
            rd_idx_reg <= rd_idx_reg + 4'd1;
        end
        if (state_reg == gniu_pkg::BK_CMP)
        begin
            rd_idx_reg  <= rd_idx_reg + 4'd1;
            cmp_idx_reg <= cmp_idx_reg + 4'd1;
            if (stored_val != gniu_pkg::NO_AREA && !found)
            begin
                drop_reg[drop_cnt_reg] <= stored_val;
                drop_cnt_reg <= drop_cnt_reg + 4'd1;
            end
        end
        if (emit_go)
        begin
            emit_reg <= emit_reg + 4'd1;
        end
    end

    // The read issued in BK_READ returns slot zero for the first compare; each
    // compare cycle then fetches the following slot.
    assign out_valid              = (state_reg == gniu_pkg::BK_EMIT);
    assign out_data.slot          = bad_reg ? 4'd0 : emit_reg;
    assign out_data.active_area   = bad_reg ? gniu_pkg::NO_AREA : fresh_reg[emit_reg];
    assign out_data.inactive_area = bad_reg ? gniu_pkg::NO_AREA : drop_reg[emit_reg];
    assign out_data.position_bad  = bad_reg;
    assign out_data.last          = bad_reg ||
                                    (emit_reg == 4'(gniu_pkg::NEIGHBOUR_SLOTS - 1));
endmodule

// ----- sv/grid_neighbourhood_interest_update_top.sv -----
// Top level of the grid neighbourhood interest update block.
// Front part: its pace per item is set by three 32-step serial divisions.
// Back part, per item: take, one read, nine compares, nine beats.
// A bad position gives one beat, the cycle after the back part takes it.
// The front part takes a new item only after it has pushed the last one into the queue.
// Reset restores register defaults; a clearing pass then sets every stored slot to no area.
module grid_neighbourhood_interest_update_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  gniu_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output gniu_pkg::out_beat_t out_data
);
    gniu_pkg::cfg_t cfg_reg;
    gniu_pkg::job_t fq_data, qb_data;
    logic fq_valid, fq_stall, qb_valid, qb_stall;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.position_columns <= 16'd240;
            cfg_reg.cell_size        <= 8'd16;
            cfg_reg.areas_per_row    <= 8'd15;
            cfg_reg.area_count       <= 8'd225;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                gniu_pkg::REG_COLS:  cfg_reg.position_columns <= pwdata[15:0];
                gniu_pkg::REG_CELL:  cfg_reg.cell_size        <= pwdata[7:0];
                gniu_pkg::REG_APR:   cfg_reg.areas_per_row    <= pwdata[7:0];
                gniu_pkg::REG_COUNT: cfg_reg.area_count       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            gniu_pkg::REG_COLS:  prdata = {16'd0, cfg_reg.position_columns};
            gniu_pkg::REG_CELL:  prdata = {24'd0, cfg_reg.cell_size};
            gniu_pkg::REG_APR:   prdata = {24'd0, cfg_reg.areas_per_row};
            gniu_pkg::REG_COUNT: prdata = {24'd0, cfg_reg.area_count};
            default:             prdata = 32'd0;
        endcase
    end

    gniu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .job_valid (fq_valid),
        .job_stall (fq_stall),
        .job       (fq_data)
    );

    gniu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_stall (fq_stall),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_stall (qb_stall),
        .rd_data  (qb_data)
    );

    gniu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (qb_valid),
        .job_stall (qb_stall),
        .job       (qb_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.position_bad |-> out_data.last)
        else $error("bad position beat without last");

    a_bad_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.position_bad |-> out_data.slot == 4'd0)
        else $error("bad position beat with nonzero slot");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.slot < 4'(gniu_pkg::NEIGHBOUR_SLOTS))
        else $error("slot index out of range");
endmodule
